/* rtl/core/mspc_pkg.sv */
package mspc_pkg;

  localparam int CMD_W       = 2;
  localparam int RAW_W       = 32;
  localparam int DIFF_W      = RAW_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int SLICE_LEN_W = 11;
  localparam int OFFSET_W    = 10;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LENGTH = 2'd1;

  localparam logic signed [RAW_W-1:0]  BIAS_RST      = -32'sd127238144;
  localparam logic [SLICE_LEN_W-1:0]   SLICE_LEN_RST = 11'd1024;

  // conditioning: floor(diff / 256) * 4, clamped to +/-32767
  localparam int DROP_SHIFT   = 8;
  localparam int SCALE_SHIFT  = 2;
  localparam int SAMPLE_LIMIT = 32767;

  typedef struct packed {
    logic [CMD_W-1:0]         op;
    logic [DIFF_W-1:0]        diff;    // raw minus bias, sign-extended
    logic                     half;    // store half touched by push or read
    logic                     rd_hit;  // read offset within the slice
    logic                     ready;   // ready flag after this item
    logic [STATUS_W-1:0]      status;
  } item_t;

endpackage

/* rtl/core/mspc_if.sv */
interface mspc_in_if;
  logic                                valid;
  logic                                ready;
  logic [mspc_pkg::CMD_W-1:0]          command;
  logic signed [mspc_pkg::RAW_W-1:0]   raw_sample;
  logic [mspc_pkg::OFFSET_W-1:0]       read_offset;

  modport source(output valid, command, raw_sample, read_offset, input ready);
  modport sink(input valid, command, raw_sample, read_offset, output ready);
endinterface

interface mspc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mspc_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 buffer_ready;
  logic [mspc_pkg::STATUS_W-1:0]        take_status;

  modport source(output valid, sample_out, buffer_ready, take_status, input ready);
  modport sink(input valid, sample_out, buffer_ready, take_status, output ready);
endinterface

interface mspc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mspc_pkg::CFG_IDX_W-1:0]    index;
  logic [mspc_pkg::RAW_W-1:0]        data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/mspc_front.sv */
module mspc_front #(
  parameter int SLICE_MAX = 1024,
  localparam int AW = $clog2(SLICE_MAX)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               acc,
  input  logic [mspc_pkg::CMD_W-1:0]         command,
  input  logic signed [mspc_pkg::RAW_W-1:0]  raw_sample,
  input  logic [mspc_pkg::OFFSET_W-1:0]      read_offset,
  input  logic                               cfg_wr,
  input  logic [mspc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mspc_pkg::RAW_W-1:0]         cfg_data,
  output mspc_pkg::item_t                    item,
  output logic [AW-1:0]                      item_idx
);
  import mspc_pkg::*;

  localparam int CW = $clog2(SLICE_MAX + 1);
  localparam int EW = (CW > SLICE_LEN_W) ? CW : SLICE_LEN_W;

  logic signed [RAW_W-1:0]  bias_r;
  logic [SLICE_LEN_W-1:0]   slice_len_r;
  logic                     active_r, active_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic                     ready_r, ready_nxt;
  logic                     overrun_r, overrun_nxt;

  logic [EW-1:0] sl;
  logic [EW-1:0] len;
  logic [EW-1:0] fill_inc;
  logic [EW-1:0] off_ext;

  always_comb begin
    sl = EW'(slice_len_r);
    if (sl == '0) begin
      len = EW'(1);
    end else if (sl > EW'(SLICE_MAX)) begin
      len = EW'(SLICE_MAX);
    end else begin
      len = sl;
    end
    fill_inc = EW'(fill_r) + EW'(1);
    off_ext  = EW'(read_offset);

    active_nxt  = active_r;
    fill_nxt    = fill_r;
    ready_nxt   = ready_r;
    overrun_nxt = overrun_r;

    item.op     = command;
    item.diff   = {raw_sample[RAW_W-1], raw_sample} - {bias_r[RAW_W-1], bias_r};
    item.half   = active_r;
    item.rd_hit = 1'b0;
    item.status = ST_OK;
    item_idx    = fill_r[AW-1:0];

    case (command)
      CMD_PUSH: begin
        // swap once the count reaches or passes the length (length may drop mid-fill)
        if (fill_inc >= len) begin
          active_nxt  = ~active_r;
          fill_nxt    = '0;
          overrun_nxt = overrun_r | ready_r;
          ready_nxt   = 1'b1;
        end else begin
          fill_nxt = fill_inc[CW-1:0];
        end
      end
      CMD_READ: begin
        item.half   = ~active_r;
        item.rd_hit = (off_ext < len);
        item_idx    = off_ext[AW-1:0];
      end
      CMD_TAKE: begin
        if (!ready_r) begin
          item.status = ST_NONE;
        end else if (overrun_r) begin
          item.status = ST_OVERRUN;
        end else begin
          item.status = ST_OK;
        end
        ready_nxt   = 1'b0;
        overrun_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    item.ready = ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r      <= BIAS_RST;
      slice_len_r <= SLICE_LEN_RST;
      active_r    <= 1'b0;
      fill_r      <= '0;
      ready_r     <= 1'b0;
      overrun_r   <= 1'b0;
    end else begin
      if (acc) begin
        active_r  <= active_nxt;
        fill_r    <= fill_nxt;
        ready_r   <= ready_nxt;
        overrun_r <= overrun_nxt;
      end
      if (cfg_wr) begin
        case (cfg_index)
          REG_BIAS:         bias_r      <= cfg_data;
          REG_SLICE_LENGTH: slice_len_r <= cfg_data[SLICE_LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/mspc_queue.sv */
module mspc_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/core/mspc_back.sv */
module mspc_back #(
  parameter int SLICE_MAX = 1024,
  localparam int AW = $clog2(SLICE_MAX)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop_valid,
  input  mspc_pkg::item_t                       item,
  input  logic [AW-1:0]                         item_idx,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mspc_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                  buffer_ready,
  output logic [mspc_pkg::STATUS_W-1:0]         take_status
);
  import mspc_pkg::*;

  localparam int QW = DIFF_W - DROP_SHIFT;
  localparam logic signed [QW-1:0] Q_HI = QW'(SAMPLE_LIMIT >> SCALE_SHIFT);

  logic signed [SAMPLE_W-1:0] mem [2][SLICE_MAX];
  logic signed [SAMPLE_W-1:0] mem_q;

  logic                       out_valid_r;
  logic                       sel_mem_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       ready_r;
  logic [STATUS_W-1:0]        status_r;

  logic signed [QW-1:0]       q;
  logic signed [SAMPLE_W-1:0] cond;

  assign pop = pop_valid && (!out_valid_r || out_ready);

  // floor shift is just dropping the low bits of the two's complement difference
  always_comb begin
    q = item.diff[DIFF_W-1:DROP_SHIFT];
    if (q > Q_HI) begin
      cond = SAMPLE_W'(SAMPLE_LIMIT);
    end else if (q < -Q_HI) begin
      cond = SAMPLE_W'(-SAMPLE_LIMIT);
    end else begin
      cond = {q[SAMPLE_W-SCALE_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (item.op == CMD_PUSH)) begin
      mem[item.half][item_idx] <= cond;
    end
    if (pop && (item.op == CMD_READ)) begin
      mem_q <= mem[item.half][item_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sel_mem_r <= (item.op == CMD_READ) && item.rd_hit;
      sample_r  <= (item.op == CMD_PUSH) ? cond : '0;
      ready_r   <= item.ready;
      status_r  <= item.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign sample_out   = sel_mem_r ? mem_q : sample_r;
  assign buffer_ready = ready_r;
  assign take_status  = status_r;

endmodule

/* rtl/core/mic_sample_pingpong_capture_core.sv */
// Ping-pong audio capture. Each input item is a push (condition one raw mic word and store
// it in the filling half), a read (one sample of the completed half) or a take (hand the
// completed half over and report ok, nothing ready or overrun); every item yields exactly
// one result. Sustained rate is one item per clock while the result side is ready: the front
// stage updates the fill count, half select and flags in the accept cycle, and the back stage
// does one store write or one registered store read per cycle. An accepted item passes
// from the front into a two-entry queue and from there into the output register, where its
// result is held valid; in_ch.ready drops only when that queue is full because the result
// side is stalled. The store holds 2 x SLICE_MAX 16-bit samples with one access per cycle,
// needs no clearing after reset, and contents of a half are defined only once that half has
// been filled. Configuration writes are always taken and apply from the next item on.
module mic_sample_pingpong_capture_core #(
  parameter int SLICE_MAX = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  mspc_in_if.sink      in_ch,
  mspc_out_if.source   out_ch,
  mspc_cfg_if.sink     cfg_ch
);
  import mspc_pkg::*;

  localparam int AW = $clog2(SLICE_MAX);
  localparam int DW = $bits(item_t) + AW;

  logic          q_ready;
  logic          acc;
  item_t         fe_item;
  logic [AW-1:0] fe_idx;
  logic          pop;
  logic          pop_valid;
  logic [DW-1:0] pop_data;
  item_t         be_item;
  logic [AW-1:0] be_idx;

  assign in_ch.ready  = q_ready;
  assign acc          = in_ch.valid && q_ready;
  assign cfg_ch.ready = 1'b1;

  mspc_front #(
    .SLICE_MAX (SLICE_MAX)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .command     (in_ch.command),
    .raw_sample  (in_ch.raw_sample),
    .read_offset (in_ch.read_offset),
    .cfg_wr      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .item        (fe_item),
    .item_idx    (fe_idx)
  );

  mspc_queue #(
    .DW (DW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .push_data  ({fe_item, fe_idx}),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  assign be_item = pop_data[DW-1:AW];
  assign be_idx  = pop_data[AW-1:0];

  mspc_back #(
    .SLICE_MAX (SLICE_MAX)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .item         (be_item),
    .item_idx     (be_idx),
    .pop          (pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sample_out   (out_ch.sample_out),
    .buffer_ready (out_ch.buffer_ready),
    .take_status  (out_ch.take_status)
  );

endmodule

/* rtl/core/mspc_checker.sv */
module mspc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [mspc_pkg::SAMPLE_W-1:0] sample_out,
  input logic                                 buffer_ready,
  input logic [mspc_pkg::STATUS_W-1:0]        take_status
);
  import mspc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(sample_out) && $stable(buffer_ready) && $stable(take_status))
    else $error("stalled result changed");

  // a take that reports nothing ready or overrun leaves the ready flag cleared
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (take_status != ST_OK) |-> !buffer_ready)
    else $error("take status reported with buffer still ready");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind mic_sample_pingpong_capture_core mspc_checker u_mspc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sample_out   (out_ch.sample_out),
  .buffer_ready (out_ch.buffer_ready),
  .take_status  (out_ch.take_status)
);
